### hdl/wsdefr_pkg.sv
// Package with the codes, constants and phase type of the WebSocket frame deframer.
package wsdefr_pkg;

  // Default width of the kept size limit and the reset value of the limit register.
  localparam int unsigned SIZE_LIMIT_WIDTH_DEF = 32;
  localparam logic [31:0] MAX_SIZE_RESET       = 32'd1048576;

  // Frame opcodes.
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Header bit masks and the two escape values of the short length.
  localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
  localparam logic [7:0] HDR_RSV_BITS = 8'h70;
  localparam logic [6:0] LEN_EXT_16   = 7'd126;
  localparam logic [6:0] LEN_EXT_64   = 7'd127;

  // Payload kinds.
  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd1;
  localparam logic [1:0] KIND_PING   = 2'd2;
  localparam logic [1:0] KIND_CLOSE  = 2'd3;

  // Events.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_FRAG_END  = 3'd1;
  localparam logic [2:0] EV_MSG_END   = 3'd2;
  localparam logic [2:0] EV_PONG_REQ  = 3'd3;
  localparam logic [2:0] EV_CLOSE     = 3'd4;
  localparam logic [2:0] EV_ERROR     = 3'd5;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_RSV        = 3'd1;
  localparam logic [2:0] ERR_FRAME_BIG  = 3'd2;
  localparam logic [2:0] ERR_BAD_OP     = 3'd3;
  localparam logic [2:0] ERR_DATA_FRAG  = 3'd4;
  localparam logic [2:0] ERR_STRAY_CONT = 3'd5;
  localparam logic [2:0] ERR_MSG_BIG    = 3'd6;

  // Close codes.
  localparam logic [15:0] CLOSE_NORMAL = 16'd1000;
  localparam logic [15:0] CLOSE_PROTO  = 16'd1002;
  localparam logic [15:0] CLOSE_BIG    = 16'd1009;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4,
    PH_HALT = 3'd5
  } phase_e;

endpackage

### hdl/websocket_frame_deframer.sv
// WebSocket frame deframer: header parsing, unmasking, checks and event generation.
// A result is registered; it shows on the master side in the cycle after its byte is taken.
// Throughput: one received byte per cycle unless the master side stalls; the byte update
// is a single pass from the state registers to the result register, which a stalled master
// side holds in place. Reset clears the parser to wait for the first header byte, empties
// the result register and sets the size limit to 1048576 (kept to SIZE_LIMIT_WIDTH bits).
module websocket_frame_deframer
  import wsdefr_pkg::*;
#(
  parameter int unsigned SIZE_LIMIT_WIDTH = SIZE_LIMIT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Size limit register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,        // size limit in bytes
  // Received byte stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,    // [7:0] rx_byte
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,    // [7:0] data, [10:8] event_res, [13:11] error_code,
                                         // [29:14] reply_close_code, [31:30] zero
  output logic [2:0]  m_axis_tuser_o     // [0] data_valid, [2:1] payload_kind
);

  localparam int unsigned SLW = SIZE_LIMIT_WIDTH;
  localparam logic [SLW-1:0] MaxSizeRst = SLW'(MAX_SIZE_RESET);

  // Parser state.
  phase_e          phase_q, phase_d;
  logic            fin_q, fin_d;
  logic [3:0]      opcode_q, opcode_d;
  logic            mask_present_q, mask_present_d;
  logic [63:0]     len_q, len_d;
  logic [2:0]      hdr_cnt_q, hdr_cnt_d;
  logic [31:0]     mask_key_q, mask_key_d;
  logic [1:0]      mask_idx_q, mask_idx_d;
  logic            in_msg_q, in_msg_d;
  logic            msg_bin_q, msg_bin_d;
  logic [SLW-1:0]  msg_cnt_q, msg_cnt_d;
  logic [15:0]     close_hold_q, close_hold_d;
  logic [1:0]      close_idx_q, close_idx_d;
  logic [SLW-1:0]  max_size_q;

  // Result register.
  logic            out_valid_q, out_valid_d;
  logic            res_dv_q, res_dv_d;
  logic [7:0]      res_data_q, res_data_d;
  logic [1:0]      res_kind_q, res_kind_d;
  logic [2:0]      res_ev_q, res_ev_d;
  logic [2:0]      res_err_q, res_err_d;
  logic [15:0]     res_reply_q, res_reply_d;

  // Decisions handed from the next-state logic to the result logic.
  logic            frame_end;
  logic [2:0]      fail_code;
  logic [7:0]      unmasked;

  logic            accept;
  logic [7:0]      rx_byte;
  logic [7:0]      key_byte;
  logic            hdr_done;
  logic [63:0]     len_new;
  logic [SLW:0]    msg_sum;
  logic            produce;

  assign rx_byte         = s_axis_tdata_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Key byte for the current payload position, most significant byte first.
  always_comb begin
    case (mask_idx_q)
      2'd0:    key_byte = mask_key_q[31:24];
      2'd1:    key_byte = mask_key_q[23:16];
      2'd2:    key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end
  assign unmasked = rx_byte ^ key_byte;

  // Message size after this continuation; the frame length is already within the limit.
  assign msg_sum = {1'b0, msg_cnt_q} + {1'b0, len_new[SLW-1:0]};

  // Next state of the parser for one byte.
  always_comb begin
    phase_d        = phase_q;
    fin_d          = fin_q;
    opcode_d       = opcode_q;
    mask_present_d = mask_present_q;
    len_d          = len_q;
    hdr_cnt_d      = hdr_cnt_q;
    mask_key_d     = mask_key_q;
    mask_idx_d     = mask_idx_q;
    in_msg_d       = in_msg_q;
    msg_bin_d      = msg_bin_q;
    msg_cnt_d      = msg_cnt_q;
    close_hold_d   = close_hold_q;
    close_idx_d    = close_idx_q;
    frame_end      = 1'b0;
    fail_code      = ERR_NONE;
    hdr_done       = 1'b0;
    len_new        = len_q;

    unique case (phase_q)
      PH_HDR0: begin
        if ((rx_byte & HDR_RSV_BITS) != 8'h00) begin
          fail_code = ERR_RSV;
        end else begin
          fin_d    = (rx_byte & HDR_FIN_BIT) != 8'h00;
          opcode_d = rx_byte[3:0];
          phase_d  = PH_HDR1;
        end
      end
      PH_HDR1: begin
        mask_present_d = rx_byte[7];
        if (rx_byte[6:0] == LEN_EXT_16) begin
          len_d     = '0;
          hdr_cnt_d = 3'd1;
          phase_d   = PH_EXT;
        end else if (rx_byte[6:0] == LEN_EXT_64) begin
          len_d     = '0;
          hdr_cnt_d = 3'd7;
          phase_d   = PH_EXT;
        end else begin
          len_new  = {57'd0, rx_byte[6:0]};
          len_d    = len_new;
          hdr_done = 1'b1;
        end
      end
      PH_EXT: begin
        len_new = {len_q[55:0], rx_byte};
        len_d   = len_new;
        if (hdr_cnt_q == 3'd0) begin
          hdr_done = 1'b1;
        end else begin
          hdr_cnt_d = hdr_cnt_q - 3'd1;
        end
      end
      PH_MASK: begin
        mask_key_d = {mask_key_q[23:0], rx_byte};
        if (hdr_cnt_q == 3'd0) begin
          mask_idx_d = 2'd0;
          if (len_q == 64'd0) begin
            frame_end = 1'b1;
          end else begin
            phase_d = PH_PAY;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_q - 3'd1;
        end
      end
      PH_PAY: begin
        mask_idx_d = mask_idx_q + 2'd1;
        len_d      = len_q - 64'd1;
        // The first two close payload bytes form the close code.
        if (opcode_q == OP_CLOSE && close_idx_q < 2'd2) begin
          close_hold_d = {close_hold_q[7:0], unmasked};
          close_idx_d  = close_idx_q + 2'd1;
        end
        if (len_q == 64'd1) begin
          frame_end = 1'b1;
        end
      end
      default: begin
        // Halted: bytes are taken and dropped.
      end
    endcase

    // Header checks once the length is complete.
    if (hdr_done) begin
      if (len_new > {{(64-SLW){1'b0}}, max_size_q}) begin
        fail_code = ERR_FRAME_BIG;
      end else begin
        case (opcode_q) inside
          OP_TEXT, OP_BINARY: begin
            if (in_msg_q) begin
              fail_code = ERR_DATA_FRAG;
            end else begin
              in_msg_d  = 1'b1;
              msg_bin_d = (opcode_q == OP_BINARY);
              msg_cnt_d = len_new[SLW-1:0];
            end
          end
          OP_CONT: begin
            if (!in_msg_q) begin
              fail_code = ERR_STRAY_CONT;
            end else if (msg_sum > {1'b0, max_size_q}) begin
              fail_code = ERR_MSG_BIG;
            end else begin
              msg_cnt_d = msg_sum[SLW-1:0];
            end
          end
          OP_CLOSE: begin
            close_hold_d = '0;
            close_idx_d  = 2'd0;
          end
          OP_PING, OP_PONG: begin
          end
          default: fail_code = ERR_BAD_OP;
        endcase
      end
      if (fail_code == ERR_NONE) begin
        mask_key_d = '0;
        mask_idx_d = 2'd0;
        if (mask_present_d) begin
          hdr_cnt_d = 3'd3;
          phase_d   = PH_MASK;
        end else if (len_new == 64'd0) begin
          frame_end = 1'b1;
        end else begin
          phase_d = PH_PAY;
        end
      end
    end

    // End of frame: close the message on a final data frame, halt on close.
    if (frame_end) begin
      phase_d = PH_HDR0;
      case (opcode_q) inside
        OP_CONT, OP_TEXT, OP_BINARY: begin
          if (fin_q) begin
            in_msg_d  = 1'b0;
            msg_cnt_d = '0;
          end
        end
        OP_CLOSE: phase_d = PH_HALT;
        default: begin
        end
      endcase
    end

    if (fail_code != ERR_NONE) begin
      phase_d = PH_HALT;
    end
  end

  // Result fields for one byte.
  always_comb begin
    res_dv_d    = 1'b0;
    res_data_d  = '0;
    res_kind_d  = KIND_TEXT;
    res_ev_d    = EV_NONE;
    res_err_d   = ERR_NONE;
    res_reply_d = '0;

    // Payload byte output.
    if (phase_q == PH_PAY) begin
      case (opcode_q) inside
        OP_CONT, OP_TEXT, OP_BINARY: begin
          res_dv_d   = 1'b1;
          res_data_d = unmasked;
          res_kind_d = msg_bin_q ? KIND_BINARY : KIND_TEXT;
        end
        OP_PING: begin
          res_dv_d   = 1'b1;
          res_data_d = unmasked;
          res_kind_d = KIND_PING;
        end
        OP_CLOSE: begin
          if (close_idx_q >= 2'd2) begin
            res_dv_d   = 1'b1;
            res_data_d = unmasked;
            res_kind_d = KIND_CLOSE;
          end
        end
        default: begin
        end
      endcase
    end

    // Event output.
    if (fail_code != ERR_NONE) begin
      res_ev_d    = EV_ERROR;
      res_err_d   = fail_code;
      res_reply_d = (fail_code == ERR_FRAME_BIG || fail_code == ERR_MSG_BIG)
                    ? CLOSE_BIG : CLOSE_PROTO;
    end else if (frame_end) begin
      case (opcode_q) inside
        OP_CONT, OP_TEXT, OP_BINARY: res_ev_d = fin_q ? EV_MSG_END : EV_FRAG_END;
        OP_PING: res_ev_d = EV_PONG_REQ;
        OP_CLOSE: begin
          res_ev_d    = EV_CLOSE;
          res_reply_d = (close_idx_d >= 2'd2) ? close_hold_d : CLOSE_NORMAL;
        end
        default: begin
        end
      endcase
    end
  end

  assign produce = res_dv_d || (res_ev_d != EV_NONE);

  // Result register handshake: load on a producing beat, drop when the master side takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && produce) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HDR0;
      fin_q          <= 1'b0;
      opcode_q       <= OP_CONT;
      mask_present_q <= 1'b0;
      len_q          <= '0;
      hdr_cnt_q      <= '0;
      mask_key_q     <= '0;
      mask_idx_q     <= '0;
      in_msg_q       <= 1'b0;
      msg_bin_q      <= 1'b0;
      msg_cnt_q      <= '0;
      close_hold_q   <= '0;
      close_idx_q    <= '0;
      max_size_q     <= MaxSizeRst;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        phase_q        <= phase_d;
        fin_q          <= fin_d;
        opcode_q       <= opcode_d;
        mask_present_q <= mask_present_d;
        len_q          <= len_d;
        hdr_cnt_q      <= hdr_cnt_d;
        mask_key_q     <= mask_key_d;
        mask_idx_q     <= mask_idx_d;
        in_msg_q       <= in_msg_d;
        msg_bin_q      <= msg_bin_d;
        msg_cnt_q      <= msg_cnt_d;
        close_hold_q   <= close_hold_d;
        close_idx_q    <= close_idx_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_size_q <= SLW'(cfg_data_i);
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept && produce) begin
      res_dv_q    <= res_dv_d;
      res_data_q  <= res_data_d;
      res_kind_q  <= res_kind_d;
      res_ev_q    <= res_ev_d;
      res_err_q   <= res_err_d;
      res_reply_q <= res_reply_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_reply_q, res_err_q, res_ev_q, res_data_q};
  assign m_axis_tuser_o  = {res_kind_q, res_dv_q};

endmodule
